// ===== sv/longest_common_subsequence_core_defines.svh =====
// Assertion macros shared by the longest common subsequence core.
// Each macro expects signals named clk and rst in the scope of its use.
`ifndef LONGEST_COMMON_SUBSEQUENCE_CORE_DEFINES_SVH
`define LONGEST_COMMON_SUBSEQUENCE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define LCS_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define LCS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/lcs_pkg.sv =====
// Shared constants, mode codes and control structs for the LCS core.
// No dependencies; every other file of the block but the defines header imports this package.
package lcs_pkg;

  localparam int MAX_LEN_DEFAULT = 32;
  localparam int SYMBOL_W        = 8;
  localparam int MODE_W          = 2;
  localparam int SUBSEQ_LEN_W    = 6;

  localparam logic [MODE_W-1:0] MODE_FIRST   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SECOND  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_COMPUTE = 2'd2;

  typedef struct packed {
    logic fill_write;
    logic zero_write;
    logic trace_mode;
  } dp_ctrl_t;

  typedef struct packed {
    logic match;
    logic up_gt_left;
  } dp_stat_t;

endpackage

// ===== sv/longest_common_subsequence_core.sv =====
// LCS core: on a load beat (mode 0 or 1) busy stays low. A compute beat holds busy
// through the fill (a border cell passes S_FILL_ISSUE only, an interior cell also
// S_FILL_WRITE, since string and table reads are registered), then a traceback of s
// steps (s at most m + n - 1), then S_EMIT_READ and S_EMIT_BEAT per result beat.
// Results go out as strobed beats that the receiver cannot stall.
// Synchronous reset clears lengths, overflow flag and sequencer.
module longest_common_subsequence_core #(
  parameter int MAX_LEN = lcs_pkg::MAX_LEN_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [lcs_pkg::MODE_W-1:0]        mode,
  input  logic [lcs_pkg::SYMBOL_W-1:0]      symbol,
  output logic                              result_valid,
  output logic [lcs_pkg::SYMBOL_W-1:0]      out_symbol,
  output logic                              has_symbol,
  output logic [lcs_pkg::SUBSEQ_LEN_W-1:0]  subsequence_length,
  output logic                              is_last,
  output logic                              truncated
);
  import lcs_pkg::*;
  `include "longest_common_subsequence_core_defines.svh"

  localparam int LEN_W   = $clog2(MAX_LEN + 1);
  localparam int IDX_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int TDIM    = MAX_LEN + 1;
  localparam int TADDR_W = $clog2(TDIM * TDIM);

  typedef enum logic [6:0] {
    S_IDLE         = 7'b0000001,
    S_FILL_ISSUE   = 7'b0000010,
    S_FILL_WRITE   = 7'b0000100,
    S_TRACE_ISSUE  = 7'b0001000,
    S_TRACE_DECIDE = 7'b0010000,
    S_EMIT_READ    = 7'b0100000,
    S_EMIT_BEAT    = 7'b1000000
  } state_t;

  state_t state;

  logic                accept;
  logic                compute_start;
  logic [LEN_W-1:0]    first_length;
  logic [LEN_W-1:0]    second_length;
  logic                overflow;
  logic [SYMBOL_W-1:0] sym_a;
  logic [SYMBOL_W-1:0] sym_b;

  logic [LEN_W-1:0] m;
  logic [LEN_W-1:0] n;
  logic [LEN_W-1:0] i;
  logic [LEN_W-1:0] j;
  logic [LEN_W-1:0] idx;
  logic [LEN_W-1:0] len;
  logic [LEN_W-1:0] k;
  logic             trunc;

  logic [LEN_W-1:0] i_dec;
  logic [LEN_W-1:0] j_dec;
  logic [LEN_W-1:0] idx_dec;
  logic [LEN_W-1:0] len_dec;
  logic [LEN_W+SUBSEQ_LEN_W-1:0] len_ext;

  logic [TADDR_W-1:0] row_base;
  logic [TADDR_W-1:0] wr_addr;
  logic [TADDR_W-1:0] up_addr;
  logic [TADDR_W-1:0] left_addr;

  dp_ctrl_t         ctrl;
  dp_stat_t         stat;
  logic [LEN_W-1:0] wr_value;

  logic [SYMBOL_W-1:0] rbuf [MAX_LEN];
  logic [SYMBOL_W-1:0] rbuf_q;
  logic                rbuf_we;

  logic border;
  logic last_cell;
  logic trace_done;
  logic last_beat;

  assign busy          = (state != S_IDLE);
  assign accept        = start && !busy;
  assign compute_start = accept && (mode == MODE_COMPUTE);

  assign i_dec     = i - LEN_W'(1);
  assign j_dec     = j - LEN_W'(1);
  assign idx_dec   = idx - LEN_W'(1);
  assign len_dec   = len - LEN_W'(1);
  assign len_ext   = {{SUBSEQ_LEN_W{1'b0}}, len};
  assign row_base  = TADDR_W'(i * TDIM);
  assign wr_addr   = row_base + TADDR_W'(j);
  assign up_addr   = wr_addr - TADDR_W'(TDIM);
  assign left_addr = wr_addr - TADDR_W'(1);

  assign border     = (i == '0) || (j == '0);
  assign last_cell  = (i == m) && (j == n);
  assign trace_done = border || (idx == '0);
  assign last_beat  = (k == len_dec);
  assign rbuf_we    = (state == S_TRACE_DECIDE) && stat.match;

  always_comb begin
    ctrl = '0;
    case (state)
      S_FILL_ISSUE:   ctrl.zero_write = border;
      S_FILL_WRITE:   ctrl.fill_write = 1'b1;
      S_TRACE_DECIDE: ctrl.trace_mode = 1'b1;
      default:        ctrl = '0;
    endcase
  end

  lcs_string_store #(.MAX_LEN(MAX_LEN)) u_store (
    .clk           (clk),
    .rst           (rst),
    .load_en       (accept),
    .mode          (mode),
    .symbol        (symbol),
    .clear         (compute_start),
    .rd_addr_a     (i_dec[IDX_W-1:0]),
    .rd_addr_b     (j_dec[IDX_W-1:0]),
    .rd_a          (sym_a),
    .rd_b          (sym_b),
    .first_length  (first_length),
    .second_length (second_length),
    .overflow      (overflow)
  );

  lcs_dp_unit #(.MAX_LEN(MAX_LEN)) u_dp (
    .clk       (clk),
    .ctrl      (ctrl),
    .wr_addr   (wr_addr),
    .up_addr   (up_addr),
    .left_addr (left_addr),
    .sym_a     (sym_a),
    .sym_b     (sym_b),
    .wr_value  (wr_value),
    .stat      (stat)
  );

  always_ff @(posedge clk) begin
    if (rbuf_we) begin
      rbuf[idx_dec[IDX_W-1:0]] <= sym_a;
    end
    rbuf_q <= rbuf[k[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (compute_start) begin
            m     <= first_length;
            n     <= second_length;
            trunc <= overflow;
            i     <= '0;
            j     <= '0;
            state <= S_FILL_ISSUE;
          end
        end
        S_FILL_ISSUE, S_FILL_WRITE: begin
          if (state == S_FILL_ISSUE && !border) begin
            state <= S_FILL_WRITE;
          end else if (last_cell) begin
            len   <= wr_value;
            idx   <= wr_value;
            state <= S_TRACE_ISSUE;
          end else begin
            if (j == n) begin
              i <= i + LEN_W'(1);
              j <= '0;
            end else begin
              j <= j + LEN_W'(1);
            end
            state <= S_FILL_ISSUE;
          end
        end
        S_TRACE_ISSUE: begin
          if (trace_done) begin
            k <= '0;
            if (len == '0) begin
              result_valid       <= 1'b1;
              out_symbol         <= '0;
              has_symbol         <= 1'b0;
              subsequence_length <= '0;
              is_last            <= 1'b1;
              truncated          <= trunc;
              state              <= S_IDLE;
            end else begin
              state <= S_EMIT_READ;
            end
          end else begin
            state <= S_TRACE_DECIDE;
          end
        end
        S_TRACE_DECIDE: begin
          if (stat.match) begin
            i   <= i_dec;
            j   <= j_dec;
            idx <= idx_dec;
          end else if (stat.up_gt_left) begin
            i <= i_dec;
          end else begin
            j <= j_dec;
          end
          state <= S_TRACE_ISSUE;
        end
        S_EMIT_READ: begin
          state <= S_EMIT_BEAT;
        end
        S_EMIT_BEAT: begin
          result_valid       <= 1'b1;
          out_symbol         <= rbuf_q;
          has_symbol         <= 1'b1;
          subsequence_length <= len_ext[SUBSEQ_LEN_W-1:0];
          is_last            <= last_beat;
          truncated          <= trunc;
          k                  <= k + LEN_W'(1);
          state              <= last_beat ? S_IDLE : S_EMIT_READ;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `LCS_ASSERT_IMP(a_empty_is_last, result_valid && !has_symbol, is_last,
                  "A beat without a symbol must be the last beat.")
  `LCS_ASSERT_NEXT(a_compute_holds_busy, compute_start, busy,
                   "A compute beat must make the core busy.")
  `LCS_ASSERT_NEXT(a_beat_spacing, result_valid && !is_last,
                   !result_valid ##1 result_valid,
                   "Result beats of one run must follow every second cycle.")
  `LCS_ASSERT_IMP(a_no_beat_in_fill, state == S_FILL_WRITE || state == S_TRACE_DECIDE,
                  !result_valid, "No result beat may appear during fill or traceback.")

endmodule

// ===== sv/lcs_string_store.sv =====
// Holds both input strings, their lengths and the overflow flag.
// Depends on lcs_pkg for the mode codes and symbol width.
module lcs_string_store #(
  parameter int MAX_LEN = lcs_pkg::MAX_LEN_DEFAULT,
  localparam int LEN_W = $clog2(MAX_LEN + 1),
  localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load_en,
  input  logic [lcs_pkg::MODE_W-1:0]    mode,
  input  logic [lcs_pkg::SYMBOL_W-1:0]  symbol,
  input  logic                          clear,
  input  logic [IDX_W-1:0]              rd_addr_a,
  input  logic [IDX_W-1:0]              rd_addr_b,
  output logic [lcs_pkg::SYMBOL_W-1:0]  rd_a,
  output logic [lcs_pkg::SYMBOL_W-1:0]  rd_b,
  output logic [LEN_W-1:0]              first_length,
  output logic [LEN_W-1:0]              second_length,
  output logic                          overflow
);
  import lcs_pkg::*;

  logic [SYMBOL_W-1:0] first_mem  [MAX_LEN];
  logic [SYMBOL_W-1:0] second_mem [MAX_LEN];

  logic first_full;
  logic second_full;
  logic first_we;
  logic second_we;

  assign first_full  = (first_length == LEN_W'(MAX_LEN));
  assign second_full = (second_length == LEN_W'(MAX_LEN));
  assign first_we    = load_en && (mode == MODE_FIRST) && !first_full;
  assign second_we   = load_en && (mode == MODE_SECOND) && !second_full;

  always_ff @(posedge clk) begin
    if (first_we) begin
      first_mem[first_length[IDX_W-1:0]] <= symbol;
    end
    if (second_we) begin
      second_mem[second_length[IDX_W-1:0]] <= symbol;
    end
    rd_a <= first_mem[rd_addr_a];
    rd_b <= second_mem[rd_addr_b];
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      first_length  <= '0;
      second_length <= '0;
      overflow      <= 1'b0;
    end else begin
      if (first_we) begin
        first_length <= first_length + LEN_W'(1);
      end
      if (second_we) begin
        second_length <= second_length + LEN_W'(1);
      end
      if (load_en && ((mode == MODE_FIRST && first_full) ||
                      (mode == MODE_SECOND && second_full))) begin
        overflow <= 1'b1;
      end
    end
  end

endmodule

// ===== sv/lcs_dp_unit.sv =====
// Length table memory with the shared compare, maximum and increment unit.
// Serves both the table fill and the traceback; depends on lcs_pkg.
module lcs_dp_unit #(
  parameter int MAX_LEN = lcs_pkg::MAX_LEN_DEFAULT,
  localparam int LEN_W   = $clog2(MAX_LEN + 1),
  localparam int TDIM    = MAX_LEN + 1,
  localparam int TDEPTH  = TDIM * TDIM,
  localparam int TADDR_W = $clog2(TDEPTH)
) (
  input  logic                          clk,
  input  lcs_pkg::dp_ctrl_t             ctrl,
  input  logic [TADDR_W-1:0]            wr_addr,
  input  logic [TADDR_W-1:0]            up_addr,
  input  logic [TADDR_W-1:0]            left_addr,
  input  logic [lcs_pkg::SYMBOL_W-1:0]  sym_a,
  input  logic [lcs_pkg::SYMBOL_W-1:0]  sym_b,
  output logic [LEN_W-1:0]              wr_value,
  output lcs_pkg::dp_stat_t             stat
);
  import lcs_pkg::*;

  logic [LEN_W-1:0] table_mem [TDEPTH];
  logic [LEN_W-1:0] up_q;
  logic [LEN_W-1:0] left_q;
  logic [LEN_W-1:0] left_reg;
  logic [LEN_W-1:0] diag_reg;
  logic [LEN_W-1:0] left_val;
  logic [LEN_W-1:0] cell_value;

  always_comb begin
    left_val        = ctrl.trace_mode ? left_q : left_reg;
    stat.match      = (sym_a == sym_b);
    stat.up_gt_left = (up_q > left_val);
    if (stat.match) begin
      cell_value = diag_reg + LEN_W'(1);
    end else if (stat.up_gt_left) begin
      cell_value = up_q;
    end else begin
      cell_value = left_val;
    end
    wr_value = ctrl.zero_write ? '0 : cell_value;
  end

  always_ff @(posedge clk) begin
    if (ctrl.fill_write || ctrl.zero_write) begin
      table_mem[wr_addr] <= wr_value;
    end
    up_q   <= table_mem[up_addr];
    left_q <= table_mem[left_addr];
  end

  always_ff @(posedge clk) begin
    if (ctrl.zero_write) begin
      left_reg <= '0;
      diag_reg <= '0;
    end else if (ctrl.fill_write) begin
      left_reg <= cell_value;
      diag_reg <= up_q;
    end
  end

endmodule

// ===== tb/longest_common_subsequence_checker.sv =====
// Checker for the LCS core: watches the load/compute channel and the result strobe,
// keeps its own copy of both strings and predicts every result beat of a compute.
// Depends on lcs_pkg for widths and mode codes.
module longest_common_subsequence_checker #(
  parameter int MAX_LEN = lcs_pkg::MAX_LEN_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic                             busy,
  input  logic [lcs_pkg::MODE_W-1:0]       mode,
  input  logic [lcs_pkg::SYMBOL_W-1:0]     symbol,
  input  logic                             result_valid,
  input  logic [lcs_pkg::SYMBOL_W-1:0]     out_symbol,
  input  logic                             has_symbol,
  input  logic [lcs_pkg::SUBSEQ_LEN_W-1:0] subsequence_length,
  input  logic                             is_last,
  input  logic                             truncated,
  output int                               errors,
  output int                               pending
);
  import lcs_pkg::*;

  typedef struct packed {
    logic [SYMBOL_W-1:0]     sym;
    logic                    has;
    logic [SUBSEQ_LEN_W-1:0] len;
    logic                    last;
    logic                    trunc;
  } subseq_beat_t;

  logic [SYMBOL_W-1:0] first_seq [MAX_LEN];
  logic [SYMBOL_W-1:0] second_seq [MAX_LEN];
  int unsigned         first_count;
  int unsigned         second_count;
  logic                dropped;
  subseq_beat_t        expected_beats [$];
  int                  mismatches;

  initial begin
    errors  = 0;
    pending = 0;
    mismatches = 0;
    first_count = 0;
    second_count = 0;
    dropped = 1'b0;
  end

  task automatic predict_compute();
    int unsigned         tbl [MAX_LEN+1][MAX_LEN+1];
    logic [SYMBOL_W-1:0] picked [MAX_LEN];
    int unsigned         total;
    int unsigned         idx;
    int unsigned         i;
    int unsigned         j;
    subseq_beat_t        beat;
    for (i = 0; i <= first_count; i++) begin
      for (j = 0; j <= second_count; j++) begin
        if (i == 0 || j == 0) begin
          tbl[i][j] = 0;
        end else if (first_seq[i-1] == second_seq[j-1]) begin
          tbl[i][j] = tbl[i-1][j-1] + 1;
        end else begin
          tbl[i][j] = (tbl[i-1][j] > tbl[i][j-1]) ? tbl[i-1][j] : tbl[i][j-1];
        end
      end
    end
    total = tbl[first_count][second_count];
    idx = total;
    i = first_count;
    j = second_count;
    while (i > 0 && j > 0 && idx > 0) begin
      if (first_seq[i-1] == second_seq[j-1]) begin
        picked[idx-1] = first_seq[i-1];
        i--;
        j--;
        idx--;
      end else if (tbl[i-1][j] > tbl[i][j-1]) begin
        i--;
      end else begin
        j--;
      end
    end
    if (total == 0) begin
      beat.sym = '0;
      beat.has = 1'b0;
      beat.len = '0;
      beat.last = 1'b1;
      beat.trunc = dropped;
      expected_beats.push_back(beat);
    end else begin
      for (idx = 0; idx < total; idx++) begin
        beat.sym = picked[idx];
        beat.has = 1'b1;
        beat.len = total[SUBSEQ_LEN_W-1:0];
        beat.last = (idx + 1 == total);
        beat.trunc = dropped;
        expected_beats.push_back(beat);
      end
    end
    first_count = 0;
    second_count = 0;
    dropped = 1'b0;
  endtask

  always @(posedge clk) begin
    subseq_beat_t want;
    subseq_beat_t got;
    got = '{out_symbol, has_symbol, subsequence_length, is_last, truncated};
    if (rst) begin
      first_count = 0;
      second_count = 0;
      dropped = 1'b0;
    end else begin
      if (result_valid) begin
        if (expected_beats.size() == 0) begin
          if (mismatches < 10) begin
            $display("unexpected result beat: sym=%h has=%b len=%0d last=%b trunc=%b",
                     got.sym, got.has, got.len, got.last, got.trunc);
          end
          mismatches++;
        end else begin
          want = expected_beats.pop_front();
          if (got.sym !== want.sym || got.has !== want.has || got.len !== want.len ||
              got.last !== want.last || got.trunc !== want.trunc) begin
            if (mismatches < 10) begin
              $display("result mismatch: expected sym=%h has=%b len=%0d last=%b trunc=%b",
                       want.sym, want.has, want.len, want.last, want.trunc);
              $display("                 actual   sym=%h has=%b len=%0d last=%b trunc=%b",
                       got.sym, got.has, got.len, got.last, got.trunc);
            end
            mismatches++;
          end
        end
      end
      if (start && !busy) begin
        case (mode)
          MODE_FIRST: begin
            if (first_count < MAX_LEN) begin
              first_seq[first_count] = symbol;
              first_count++;
            end else begin
              dropped = 1'b1;
            end
          end
          MODE_SECOND: begin
            if (second_count < MAX_LEN) begin
              second_seq[second_count] = symbol;
              second_count++;
            end else begin
              dropped = 1'b1;
            end
          end
          MODE_COMPUTE: begin
            predict_compute();
          end
          default: begin
          end
        endcase
      end
    end
    errors <= mismatches;
    pending <= expected_beats.size();
  end

endmodule

// ===== tb/longest_common_subsequence_core_test.sv =====
// Top of the LCS core testbench: clock, reset and load/compute stimulus in bursts.
// Depends on lcs_pkg, the core and longest_common_subsequence_checker, which predicts
// and compares every result beat and reports its failure count here.
module longest_common_subsequence_core_test;
  import lcs_pkg::*;

  localparam int MAX_LEN = 32;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEM_TARGET = 210;
  localparam int DRAIN_CYCLES = 200;

  logic                    clk = 1'b0;
  logic                    rst;
  logic                    start;
  logic                    busy;
  logic [MODE_W-1:0]       mode;
  logic [SYMBOL_W-1:0]     symbol;
  logic                    result_valid;
  logic [SYMBOL_W-1:0]     out_symbol;
  logic                    has_symbol;
  logic [SUBSEQ_LEN_W-1:0] subsequence_length;
  logic                    is_last;
  logic                    truncated;
  int                      errors;
  int                      pending;
  int                      cycle_count = 0;
  int                      burst_left = 0;
  int                      items_sent = 0;

  longest_common_subsequence_core #(.MAX_LEN(MAX_LEN)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .mode(mode), .symbol(symbol),
    .result_valid(result_valid), .out_symbol(out_symbol), .has_symbol(has_symbol),
    .subsequence_length(subsequence_length), .is_last(is_last), .truncated(truncated)
  );

  longest_common_subsequence_checker #(.MAX_LEN(MAX_LEN)) lcs_check (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .mode(mode), .symbol(symbol),
    .result_valid(result_valid), .out_symbol(out_symbol), .has_symbol(has_symbol),
    .subsequence_length(subsequence_length), .is_last(is_last), .truncated(truncated),
    .errors(errors), .pending(pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_beat(input logic [MODE_W-1:0] beat_mode,
                           input logic [SYMBOL_W-1:0] beat_symbol);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 5);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    start <= 1'b1;
    mode <= beat_mode;
    symbol <= beat_symbol;
    do @(posedge clk); while (busy);
    burst_left--;
    if (beat_mode != MODE_UNUSED) items_sent++;
  endtask

  function automatic logic [SYMBOL_W-1:0] pick_symbol(input logic [SYMBOL_W-1:0] base,
                                                      input int alphabet);
    if (alphabet >= 256) return SYMBOL_W'($urandom_range(0, 255));
    return base + SYMBOL_W'($urandom_range(0, alphabet - 1));
  endfunction

  // Loads both strings in a random interleaving, with occasional ignored beats, then
  // computes. With mirror set the second string copies the start of the first.
  task automatic run_subseq_case(input int len_a, input int len_b, input int alphabet,
                                 input bit mirror);
    logic [SYMBOL_W-1:0] seq_a [40];
    logic [SYMBOL_W-1:0] seq_b [40];
    logic [SYMBOL_W-1:0] base;
    int ia;
    int ib;
    base = SYMBOL_W'($urandom_range(0, 255));
    for (int k = 0; k < 40; k++) begin
      seq_a[k] = pick_symbol(base, alphabet);
      seq_b[k] = mirror ? seq_a[k] : pick_symbol(base, alphabet);
    end
    ia = 0;
    ib = 0;
    while (ia < len_a || ib < len_b) begin
      if ($urandom_range(0, 15) == 0) begin
        send_beat(MODE_UNUSED, SYMBOL_W'($urandom_range(0, 255)));
      end else if (ib >= len_b || (ia < len_a && $urandom_range(0, 1) == 0)) begin
        send_beat(MODE_FIRST, seq_a[ia]);
        ia++;
      end else begin
        send_beat(MODE_SECOND, seq_b[ib]);
        ib++;
      end
    end
    send_beat(MODE_COMPUTE, SYMBOL_W'($urandom_range(0, 255)));
  endtask

  function automatic int pick_length();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return $urandom_range(0, 8);
    if (roll < 93) return $urandom_range(9, MAX_LEN);
    return $urandom_range(MAX_LEN + 1, MAX_LEN + 4);
  endfunction

  initial begin
    int alphabet;
    rst <= 1'b1;
    start <= 1'b0;
    mode <= MODE_FIRST;
    symbol <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    send_beat(MODE_COMPUTE, 8'h00);
    send_beat(MODE_UNUSED, 8'hFF);
    send_beat(MODE_FIRST, 8'h00);
    send_beat(MODE_FIRST, 8'hFF);
    send_beat(MODE_SECOND, 8'hFF);
    send_beat(MODE_SECOND, 8'h00);
    send_beat(MODE_COMPUTE, 8'hFF);
    send_beat(MODE_FIRST, 8'h01);
    send_beat(MODE_FIRST, 8'h02);
    send_beat(MODE_FIRST, 8'h03);
    send_beat(MODE_SECOND, 8'h04);
    send_beat(MODE_SECOND, 8'h05);
    send_beat(MODE_COMPUTE, 8'h00);
    send_beat(MODE_SECOND, 8'h07);
    send_beat(MODE_COMPUTE, 8'h00);
    send_beat(MODE_FIRST, 8'h5A);
    send_beat(MODE_FIRST, 8'h5A);
    send_beat(MODE_SECOND, 8'h5A);
    send_beat(MODE_UNUSED, 8'h00);
    send_beat(MODE_COMPUTE, 8'h00);

    run_subseq_case(MAX_LEN + 1, MAX_LEN, 256, 1'b1);
    run_subseq_case(5, MAX_LEN + 2, 4, 1'b0);
    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 3))
        0: alphabet = 2;
        1: alphabet = 4;
        2: alphabet = 16;
        default: alphabet = 256;
      endcase
      run_subseq_case(pick_length(), pick_length(), alphabet, $urandom_range(0, 7) == 0);
    end
    start <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
